>>> hdl/c_sle_pkg.sv
`timescale 1ns / 1ps

package c_sle_pkg;

  typedef enum logic [1:0] {
    CmdBegin = 2'd0,
    CmdData  = 2'd1,
    CmdEnd   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_e;

  localparam logic [1:0] CfgQuoteKind       = 2'd0;
  localparam logic [1:0] CfgDoubleBackslash = 2'd1;
  localparam logic [1:0] CfgHexUpper        = 2'd2;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChSingleQ   = 8'h27;
  localparam logic [7:0] ChDoubleQ   = 8'h22;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChDelete    = 8'h7F;
  localparam logic [7:0] ChLastCtrl  = 8'h1F;

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    logic [7:0] base;
    base = upper ? 8'h41 : 8'h61;
    if (v < 4'd10) begin
      hex_char = 8'h30 + {4'd0, v};
    end else begin
      hex_char = base + {4'd0, v} - 8'd10;
    end
  endfunction

endpackage

>>> hdl/c_string_literal_escaper.sv
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// input    in_valid_i / in_ready_o  cmd_i, in_byte_i
// output   out_valid_o / out_ready_i out_byte_o, last_o
// config   cfg_we_i                 cfg_index_i, cfg_data_i
//
// An item is encoded in the cycle it is accepted; its zero to four characters
// sit in a result register read out by an index, one character per cycle
// while out_ready_i is high. A new item is taken in the same cycle the last
// character of the previous one leaves, so plain bytes flow at one item per
// cycle while the output is ready. Reset restores the default registers and
// closes any nested quote; a stalled output simply holds the input off.

module c_string_literal_escaper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [1:0]          cfg_data_i
);
  import c_sle_pkg::*;

  logic [1:0] quote_kind_q;
  logic       dbl_bs_q;
  logic       hex_upper_q;
  logic [1:0] nested_q, nested_d;

  logic       buf_valid_q;
  logic [7:0] seq_q [4];
  logic [1:0] cnt_q;
  logic [1:0] idx_q;

  logic [7:0] seq_d [4];
  logic [1:0] cnt_d;
  logic       emit_d;
  logic [7:0] q_char;
  logic       has_q;
  logic       in_acc;
  logic       out_done;
  logic [1:0] kind;

  always_comb begin
    unique case (quote_kind_q)
      QuoteSingle: q_char = ChSingleQ;
      QuoteDouble: q_char = ChDoubleQ;
      default:     q_char = 8'h00;
    endcase
    has_q = (q_char != 8'h00);
  end

  always_comb begin
    seq_d[0] = in_byte_i;
    seq_d[1] = 8'h00;
    seq_d[2] = 8'h00;
    seq_d[3] = 8'h00;
    cnt_d    = 2'd0;
    emit_d   = 1'b0;
    nested_d = nested_q;
    kind     = (in_byte_i == ChSingleQ) ? QuoteSingle : QuoteDouble;
    unique case (cmd_e'(cmd_i))
      CmdBegin: begin
        nested_d = QuoteNone;
        emit_d   = has_q;
        seq_d[0] = q_char;
      end
      CmdEnd: begin
        emit_d   = has_q;
        seq_d[0] = q_char;
      end
      CmdData: begin
        emit_d   = 1'b1;
        seq_d[0] = ChBackslash;
        cnt_d    = 2'd1;
        priority case (in_byte_i)
          8'h07: seq_d[1] = 8'h61;
          8'h08: seq_d[1] = 8'h62;
          8'h0C: seq_d[1] = 8'h66;
          8'h0A: seq_d[1] = 8'h6E;
          8'h0D: seq_d[1] = 8'h72;
          8'h09: seq_d[1] = 8'h74;
          8'h0B: seq_d[1] = 8'h76;
          ChQuestion: seq_d[1] = ChQuestion;
          ChBackslash: begin
            if (nested_q == QuoteNone && !dbl_bs_q) begin
              cnt_d = 2'd0;
            end else begin
              seq_d[1] = ChBackslash;
            end
          end
          ChSingleQ, ChDoubleQ: begin
            if (in_byte_i == q_char) begin
              seq_d[1] = in_byte_i;
            end else begin
              seq_d[0] = in_byte_i;
              cnt_d    = 2'd0;
            end
            if (nested_q == QuoteNone) begin
              nested_d = kind;
            end else if (nested_q == kind) begin
              nested_d = QuoteNone;
            end
          end
          default: begin
            if (in_byte_i <= ChLastCtrl || in_byte_i == ChDelete) begin
              seq_d[1] = ChLowerX;
              seq_d[2] = hex_char(in_byte_i[7:4], hex_upper_q);
              seq_d[3] = hex_char(in_byte_i[3:0], hex_upper_q);
              cnt_d    = 2'd3;
            end else begin
              seq_d[0] = in_byte_i;
              cnt_d    = 2'd0;
            end
          end
        endcase
      end
      default: begin
        emit_d = 1'b0;
      end
    endcase
  end

  assign out_done    = buf_valid_q && out_ready_i && (idx_q == cnt_q);
  assign in_ready_o  = !buf_valid_q || out_done;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = buf_valid_q;
  assign out_byte_o  = seq_q[idx_q];
  assign last_o      = (idx_q == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_kind_q <= QuoteDouble;
      dbl_bs_q     <= 1'b0;
      hex_upper_q  <= 1'b0;
      nested_q     <= QuoteNone;
      buf_valid_q  <= 1'b0;
      idx_q        <= 2'd0;
      cnt_q        <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgQuoteKind:       quote_kind_q <= cfg_data_i;
          CfgDoubleBackslash: dbl_bs_q     <= cfg_data_i[0];
          CfgHexUpper:        hex_upper_q  <= cfg_data_i[0];
          default:            ;
        endcase
      end
      if (in_acc) begin
        nested_q    <= nested_d;
        buf_valid_q <= emit_d;
        cnt_q       <= cnt_d;
        idx_q       <= 2'd0;
      end else if (buf_valid_q && out_ready_i) begin
        if (idx_q == cnt_q) begin
          buf_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      seq_q <= seq_d;
    end
  end

endmodule
